/* src/ffca_pkg.sv */
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and codes of the first-fit cell allocator: request codes,
// owner tracker commands and the fixed widths of the transaction fields.
// ----------------------------------------------------------------------------
`default_nettype none

package ffca_pkg;

  // request codes carried by in_req_type
  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  // commands from the sequencer to the owner tracker
  typedef enum logic [2:0] {
    OWN_NOP,
    OWN_LOOKUP,
    OWN_SET,
    OWN_CLEAR,
    OWN_WIPE
  } own_op_t;

  // fixed field widths of the transaction ports
  typedef logic [7:0]  owner_id_t;
  typedef logic [10:0] size_t;
  typedef logic [9:0]  start_t;
  typedef logic [10:0] frag_t;
  typedef logic [8:0]  count_t;

endpackage

`default_nettype wire

/* src/first_fit_cell_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_cell_allocator_core
// Cell array in a synchronous memory, one owner id per cell, with first-fit
// allocation, per-owner free, fragmentation query and clear.
// ----------------------------------------------------------------------------
// Usage: drive in_req_type, in_owner_id and in_block_size and raise start
// while busy is low; the transaction is taken at that edge. Exactly one
// result follows, shown for one cycle with out_valid high. The receiver
// cannot stall, so results are never held back.
// One cell read per cycle through the cell memory port. An allocate scans
// until the first fitting run is found, then claims its cells; a failed
// search scans every cell, and a zero or oversize request is answered
// without a scan. Free and query scan every cell; clear sweeps both
// memories.
// A new request may be taken in the cycle its predecessor's result is shown.
// After reset the block runs a clearing pass over the cell and owner
// memories with busy high; it gives no result. out_owner_count holds the
// count after the latest transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_cell_allocator_core #(
  parameter int CELLS      = 1024,
  parameter int OWNER_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_req_type,
  input  wire ffca_pkg::owner_id_t   in_owner_id,
  input  wire ffca_pkg::size_t       in_block_size,
  output logic                       out_valid,
  output logic                       out_ok,
  output ffca_pkg::start_t           out_start_index,
  output ffca_pkg::frag_t            out_fragment_total,
  output ffca_pkg::count_t           out_owner_count
);

  localparam int CW        = $clog2(CELLS);
  localparam int RW        = $clog2(CELLS + 1);
  localparam int SZW       = (RW > $bits(ffca_pkg::size_t)) ? RW : $bits(ffca_pkg::size_t);
  localparam int SLOTS     = 1 << OWNER_BITS;
  localparam int SWEEP_N   = (CELLS > SLOTS) ? CELLS : SLOTS;
  localparam int SWW       = $clog2(SWEEP_N);
  localparam logic [CW-1:0]  LAST_CELL  = CW'(CELLS - 1);
  localparam logic [SWW-1:0] SWEEP_LAST = SWW'(SWEEP_N - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_WIPE
  } state_t;

  state_t                  state_r;
  logic [SWW-1:0]          sweep_r;
  logic                    report_r;
  ffca_pkg::req_t          req_r;
  logic [OWNER_BITS-1:0]   who_r;
  ffca_pkg::size_t         size_r;
  logic [CW-1:0]           issue_r;
  logic                    issuing_r;
  logic                    qv_r;
  logic [CW-1:0]           qa_r;
  logic [OWNER_BITS:0]     mem_q_r;
  logic [RW-1:0]           run_r;
  logic [RW-1:0]           sum_r;
  logic [CW-1:0]           start_r;
  logic [CW-1:0]           fill_r;
  logic [CW-1:0]           fill_end_r;
  logic                    out_valid_r;
  logic                    out_ok_r;
  ffca_pkg::start_t        out_start_r;
  ffca_pkg::frag_t         out_frag_r;

  // cell memory: used flag on top, owner id below
  logic [OWNER_BITS:0]     cell_mem [CELLS];

  logic                    accept;
  ffca_pkg::req_t          req_in;
  logic [OWNER_BITS-1:0]   who_in;
  logic                    size_bad;
  logic                    cell_used;
  logic [OWNER_BITS-1:0]   cell_own;
  logic [RW-1:0]           run_inc;
  logic [RW-1:0]           run_nxt;
  logic                    hit;
  logic                    last_q;
  logic [RW-1:0]           sum_add;
  logic [RW-1:0]           sum_fin;
  logic [CW-1:0]           grant_start;
  logic                    sweep_in_cells;
  logic                    sweep_in_slots;
  logic                    we;
  logic [CW-1:0]           wa;
  logic [OWNER_BITS:0]     wd;
  ffca_pkg::own_op_t       own_op;
  logic [OWNER_BITS-1:0]   own_id;
  logic [OWNER_BITS:0]     owner_total;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign req_in = ffca_pkg::req_t'(in_req_type);
  assign who_in = OWNER_BITS'(in_owner_id);
  assign size_bad = (in_block_size == '0) || (32'(in_block_size) > 32'(CELLS));

  // run tracking on the cell read back from memory
  always_comb begin
    cell_used   = mem_q_r[OWNER_BITS];
    cell_own    = mem_q_r[OWNER_BITS-1:0];
    run_inc     = run_r + 1'b1;
    run_nxt     = cell_used ? '0 : run_inc;
    hit         = !cell_used && (SZW'(run_inc) == SZW'(size_r));
    last_q      = (qa_r == LAST_CELL);
    sum_add     = sum_r;
    if (cell_used && run_r != '0 && SZW'(run_r) < SZW'(size_r)) begin
      sum_add = sum_r + run_r;
    end
    sum_fin     = sum_add;
    if (run_nxt != '0 && SZW'(run_nxt) < SZW'(size_r)) begin
      sum_fin = sum_add + run_nxt;
    end
    grant_start = CW'(SZW'(qa_r) + SZW'(1) - SZW'(size_r));
  end

  assign sweep_in_cells = (32'(sweep_r) < 32'(CELLS));
  assign sweep_in_slots = (32'(sweep_r) < 32'(SLOTS));

  // cell memory write port select
  always_comb begin
    we = 1'b0;
    wa = qa_r;
    wd = '0;
    unique case (state_r)
      S_WIPE: begin
        we = sweep_in_cells;
        wa = CW'(sweep_r);
      end
      S_SCAN: begin
        we = qv_r && (req_r == ffca_pkg::REQ_FREE) && cell_used && (cell_own == who_r);
      end
      S_FILL: begin
        we = 1'b1;
        wa = fill_r;
        wd = {1'b1, who_r};
      end
      S_IDLE: begin
        we = 1'b0;
      end
    endcase
  end

  // owner tracker commands
  always_comb begin
    own_op = ffca_pkg::OWN_NOP;
    own_id = who_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          own_op = ffca_pkg::OWN_LOOKUP;
          own_id = who_in;
        end
      end
      S_WIPE: begin
        if (sweep_in_slots) begin
          own_op = ffca_pkg::OWN_WIPE;
          own_id = OWNER_BITS'(sweep_r);
        end
      end
      S_SCAN: begin
        if (qv_r && last_q && req_r == ffca_pkg::REQ_FREE) own_op = ffca_pkg::OWN_CLEAR;
      end
      S_FILL: begin
        if (fill_r == fill_end_r) own_op = ffca_pkg::OWN_SET;
      end
    endcase
  end

  // cell memory; reads and writes never hit the same cell in one cycle,
  // since a free scan writes the cell behind the one being read
  always_ff @(posedge clk) begin
    if (we) begin
      cell_mem[wa] <= wd;
    end
    if (state_r == S_SCAN && issuing_r) begin
      mem_q_r <= cell_mem[issue_r];
    end
  end

  // sequencer: state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WIPE;
      sweep_r     <= '0;
      report_r    <= 1'b0;
      issuing_r   <= 1'b0;
      qv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r   <= req_in;
            who_r   <= who_in;
            size_r  <= in_block_size;
            run_r   <= '0;
            sum_r   <= '0;
            issue_r <= '0;
            qv_r    <= 1'b0;
            unique case (req_in)
              ffca_pkg::REQ_ALLOC: begin
                if (size_bad) begin
                  out_valid_r <= 1'b1;
                  out_ok_r    <= 1'b0;
                  out_start_r <= '0;
                  out_frag_r  <= '0;
                end else begin
                  state_r   <= S_SCAN;
                  issuing_r <= 1'b1;
                end
              end
              ffca_pkg::REQ_FREE, ffca_pkg::REQ_QUERY: begin
                state_r   <= S_SCAN;
                issuing_r <= 1'b1;
              end
              ffca_pkg::REQ_CLEAR: begin
                state_r  <= S_WIPE;
                sweep_r  <= '0;
                report_r <= 1'b1;
              end
            endcase
          end
        end

        S_SCAN: begin
          // read side walks the cells, compare side sees each cell in the cycle after its read
          if (issuing_r) begin
            issue_r <= issue_r + 1'b1;
            if (issue_r == LAST_CELL) issuing_r <= 1'b0;
          end
          qv_r <= issuing_r;
          qa_r <= issue_r;
          if (qv_r) begin
            run_r <= run_nxt;
            sum_r <= sum_add;
            if (req_r == ffca_pkg::REQ_ALLOC && hit) begin
              state_r    <= S_FILL;
              issuing_r  <= 1'b0;
              fill_r     <= grant_start;
              fill_end_r <= qa_r;
              start_r    <= grant_start;
            end else if (last_q) begin
              state_r     <= S_IDLE;
              issuing_r   <= 1'b0;
              out_valid_r <= 1'b1;
              out_ok_r    <= (req_r != ffca_pkg::REQ_ALLOC);
              out_start_r <= '0;
              out_frag_r  <= (req_r == ffca_pkg::REQ_QUERY) ? ffca_pkg::frag_t'(sum_fin) : '0;
            end
          end
        end

        S_FILL: begin
          // claim the granted run one cell per cycle
          fill_r <= fill_r + 1'b1;
          if (fill_r == fill_end_r) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_ok_r    <= 1'b1;
            out_start_r <= ffca_pkg::start_t'(start_r);
            out_frag_r  <= '0;
          end
        end

        S_WIPE: begin
          // clearing pass over both memories
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == SWEEP_LAST) begin
            state_r  <= S_IDLE;
            report_r <= 1'b0;
            if (report_r) begin
              out_valid_r <= 1'b1;
              out_ok_r    <= 1'b1;
              out_start_r <= '0;
              out_frag_r  <= '0;
            end
          end
        end
      endcase
    end
  end

  ffca_owner_track #(
    .OWNER_BITS (OWNER_BITS)
  ) u_owner (
    .clk         (clk),
    .rst_n       (rst_n),
    .own_op      (own_op),
    .own_id      (own_id),
    .owner_total (owner_total)
  );

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_start_index    = out_start_r;
  assign out_fragment_total = out_frag_r;
  assign out_owner_count    = ffca_pkg::count_t'(owner_total);

endmodule

`default_nettype wire

/* src/ffca_owner_track.sv */
// ----------------------------------------------------------------------------
// ffca_owner_track
// Presence bit per owner in a synchronous memory plus the running count of
// owners that hold cells. Presence is looked up when a request starts and
// updated when it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ffca_owner_track #(
  parameter int OWNER_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ffca_pkg::own_op_t       own_op,
  input  wire logic [OWNER_BITS-1:0]   own_id,
  output logic      [OWNER_BITS:0]     owner_total
);

  localparam int SLOTS = 1 << OWNER_BITS;

  logic                  present_mem [SLOTS];
  logic                  present_r;
  logic [OWNER_BITS:0]   total_r;

  // presence memory: registered lookup, one write per cycle
  always_ff @(posedge clk) begin
    if (own_op == ffca_pkg::OWN_LOOKUP) begin
      present_r <= present_mem[own_id];
    end
    if (own_op == ffca_pkg::OWN_SET) begin
      present_mem[own_id] <= 1'b1;
    end else if (own_op == ffca_pkg::OWN_CLEAR || own_op == ffca_pkg::OWN_WIPE) begin
      present_mem[own_id] <= 1'b0;
    end
  end

  // owner count follows the presence bit read at request start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      unique case (own_op)
        ffca_pkg::OWN_SET: begin
          if (!present_r) total_r <= total_r + 1'b1;
        end
        ffca_pkg::OWN_CLEAR: begin
          if (present_r) total_r <= total_r - 1'b1;
        end
        ffca_pkg::OWN_WIPE: begin
          total_r <= '0;
        end
        default: begin
          total_r <= total_r;
        end
      endcase
    end
  end

  assign owner_total = total_r;

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for first_fit_cell_allocator_core. An initial block
// queues allocate, free, query and clear transactions: a directed opening
// over the corner cases, then random traffic in phases with and without
// sender gaps. A clocked driver issues them on the start/busy handshake and
// updates a cell map of its own for each accepted transaction. A monitor
// checks every result against the oldest predicted reply, field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int CELLS       = 1024;
  localparam int OWNER_SLOTS = 256;
  localparam int POOL        = 12;
  localparam int DRAIN_WAIT  = 2100;

  typedef struct {
    ffca_pkg::req_t      kind;
    ffca_pkg::owner_id_t who;
    ffca_pkg::size_t     span;
  } alloc_req_t;

  typedef struct {
    logic             ok;
    ffca_pkg::start_t first_cell;
    ffca_pkg::frag_t  short_sum;
    ffca_pkg::count_t holders;
  } alloc_reply_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                start         = 1'b0;
  logic [1:0]          in_req_type   = ffca_pkg::REQ_ALLOC;
  ffca_pkg::owner_id_t in_owner_id   = '0;
  ffca_pkg::size_t     in_block_size = '0;
  logic                busy;
  logic                out_valid;
  logic                out_ok;
  ffca_pkg::start_t    out_start_index;
  ffca_pkg::frag_t     out_fragment_total;
  ffca_pkg::count_t    out_owner_count;

  alloc_req_t          request_q[$];
  alloc_reply_t        replies_due[$];
  int unsigned         idle_pct       = 0;
  int unsigned         mismatch_count = 0;
  ffca_pkg::owner_id_t owner_pool[POOL];

  // cell map shadow
  bit                  cell_taken[CELLS];
  ffca_pkg::owner_id_t cell_holder[CELLS];
  bit                  owner_live[OWNER_SLOTS];
  int unsigned         live_owners = 0;

  first_fit_cell_allocator_core #(
    .CELLS      (CELLS),
    .OWNER_BITS (8)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_owner_id        (in_owner_id),
    .in_block_size      (in_block_size),
    .out_valid          (out_valid),
    .out_ok             (out_ok),
    .out_start_index    (out_start_index),
    .out_fragment_total (out_fragment_total),
    .out_owner_count    (out_owner_count)
  );

  always #1 clk = ~clk;

  // apply one transaction to the shadow cell map and return its reply
  function automatic alloc_reply_t apply_request(input ffca_pkg::req_t kind,
                                                 input ffca_pkg::owner_id_t who,
                                                 input ffca_pkg::size_t span);
    alloc_reply_t r;
    int need;
    int run;
    int first;
    int sum;
    r     = '{ok: 1'b1, first_cell: '0, short_sum: '0, holders: '0};
    need  = int'(span);
    run   = 0;
    first = -1;
    sum   = 0;
    case (kind)
      ffca_pkg::REQ_ALLOC: begin
        // first fit: lowest run of need free cells
        if (need != 0 && need <= CELLS) begin
          for (int i = 0; i < CELLS && first < 0; i++) begin
            if (!cell_taken[i]) begin
              run++;
              if (run == need) first = i + 1 - need;
            end else begin
              run = 0;
            end
          end
        end
        if (first >= 0) begin
          for (int j = first; j < first + need; j++) begin
            cell_taken[j]  = 1'b1;
            cell_holder[j] = who;
          end
          if (!owner_live[who]) begin
            owner_live[who] = 1'b1;
            live_owners++;
          end
          r.first_cell = ffca_pkg::start_t'(first);
        end else begin
          r.ok = 1'b0;
        end
      end
      ffca_pkg::REQ_FREE: begin
        for (int i = 0; i < CELLS; i++) begin
          if (cell_taken[i] && cell_holder[i] == who) cell_taken[i] = 1'b0;
        end
        if (owner_live[who]) begin
          owner_live[who] = 1'b0;
          live_owners--;
        end
      end
      ffca_pkg::REQ_QUERY: begin
        // sum of maximal free runs shorter than the threshold
        for (int i = 0; i < CELLS; i++) begin
          if (!cell_taken[i]) begin
            run++;
          end else begin
            if (run > 0 && run < need) sum += run;
            run = 0;
          end
        end
        if (run > 0 && run < need) sum += run;
        r.short_sum = ffca_pkg::frag_t'(sum);
      end
      default: begin
        for (int i = 0; i < CELLS; i++) cell_taken[i] = 1'b0;
        for (int k = 0; k < OWNER_SLOTS; k++) owner_live[k] = 1'b0;
        live_owners = 0;
      end
    endcase
    r.holders = ffca_pkg::count_t'(live_owners);
    return r;
  endfunction

  task automatic push_request(input ffca_pkg::req_t kind, input int who, input int span);
    request_q.push_back('{kind: kind, who: ffca_pkg::owner_id_t'(who),
                          span: ffca_pkg::size_t'(span)});
  endtask

  // random traffic: mostly allocate/free churn over a small owner pool
  task automatic queue_random(input int count);
    int roll;
    int pick;
    int who;
    int span;
    for (int k = 0; k < POOL; k++) owner_pool[k] = ffca_pkg::owner_id_t'($urandom_range(255));
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      who  = ($urandom_range(9) < 8) ? int'(owner_pool[$urandom_range(POOL - 1)])
                                     : int'($urandom_range(255));
      if (roll < 55) begin
        pick = $urandom_range(99);
        if (pick < 70)      span = $urandom_range(40, 1);
        else if (pick < 88) span = $urandom_range(300, 41);
        else if (pick < 95) span = $urandom_range(1024, 301);
        else if (pick < 98) span = 0;
        else                span = $urandom_range(2047, 1025);
        push_request(ffca_pkg::REQ_ALLOC, who, span);
      end else if (roll < 80) begin
        push_request(ffca_pkg::REQ_FREE, who, $urandom_range(2047));
      end else if (roll < 97) begin
        span = ($urandom_range(3) != 0) ? $urandom_range(64) : $urandom_range(2047);
        push_request(ffca_pkg::REQ_QUERY, $urandom_range(255), span);
      end else begin
        push_request(ffca_pkg::REQ_CLEAR, $urandom_range(255), $urandom_range(2047));
      end
    end
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || replies_due.size() != 0) @(negedge clk);
  endtask

  // driver: predict on acceptance, then offer the next transaction or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        replies_due.push_back(apply_request(ffca_pkg::req_t'(in_req_type), in_owner_id,
                                            in_block_size));
        void'(request_q.pop_front());
      end
      if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start         <= 1'b1;
        in_req_type   <= request_q[0].kind;
        in_owner_id   <= request_q[0].who;
        in_block_size <= request_q[0].span;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results are stable for the whole strobe cycle, sample mid-cycle
  always @(negedge clk) begin
    alloc_reply_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (replies_due.size() == 0) begin
        $error("result with no transaction outstanding");
        mismatch_count++;
      end else begin
        want = replies_due.pop_front();
        if (out_ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_ok);
          mismatch_count++;
        end
        if (out_start_index !== want.first_cell) begin
          $error("start_index: expected %0d, got %0d", want.first_cell, out_start_index);
          mismatch_count++;
        end
        if (out_fragment_total !== want.short_sum) begin
          $error("fragment_total: expected %0d, got %0d", want.short_sum,
                 out_fragment_total);
          mismatch_count++;
        end
        if (out_owner_count !== want.holders) begin
          $error("owner_count: expected %0d, got %0d", want.holders, out_owner_count);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus and phase control
  initial begin
    int unsigned gap_plan[4];
    gap_plan = '{0, 58, 0, 26};

    // directed: empty map, bad sizes, full map, holes, repeat owners, last cell
    push_request(ffca_pkg::REQ_QUERY, 0, 0);
    push_request(ffca_pkg::REQ_QUERY, 255, 1);
    push_request(ffca_pkg::REQ_QUERY, 0, 2047);
    push_request(ffca_pkg::REQ_QUERY, 0, 1024);
    push_request(ffca_pkg::REQ_QUERY, 0, 1025);
    push_request(ffca_pkg::REQ_ALLOC, 5, 0);
    push_request(ffca_pkg::REQ_ALLOC, 5, 1025);
    push_request(ffca_pkg::REQ_ALLOC, 5, 2047);
    push_request(ffca_pkg::REQ_ALLOC, 255, 1024);
    push_request(ffca_pkg::REQ_ALLOC, 0, 1);
    push_request(ffca_pkg::REQ_FREE, 0, 0);
    push_request(ffca_pkg::REQ_FREE, 255, 2047);
    push_request(ffca_pkg::REQ_ALLOC, 0, 10);
    push_request(ffca_pkg::REQ_ALLOC, 170, 20);
    push_request(ffca_pkg::REQ_ALLOC, 85, 5);
    push_request(ffca_pkg::REQ_ALLOC, 0, 7);
    push_request(ffca_pkg::REQ_FREE, 170, 0);
    push_request(ffca_pkg::REQ_ALLOC, 3, 25);
    push_request(ffca_pkg::REQ_ALLOC, 4, 15);
    push_request(ffca_pkg::REQ_QUERY, 0, 6);
    push_request(ffca_pkg::REQ_ALLOC, 9, 1000);
    push_request(ffca_pkg::REQ_CLEAR, 0, 0);
    push_request(ffca_pkg::REQ_ALLOC, 128, 1023);
    push_request(ffca_pkg::REQ_ALLOC, 127, 1);
    push_request(ffca_pkg::REQ_QUERY, 0, 2);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    wait_drained();

    foreach (gap_plan[p]) begin
      idle_pct = gap_plan[p];
      queue_random(139);
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
